[design/qat_pkg.sv]
package qat_pkg;

  // Byte classes produced by the front end
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SEP,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_END
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t   cls;
    logic [7:0]  ch;
    logic [7:0]  esc_ch;
  } token_t;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_ARG_END = 2'd1;
  localparam logic [1:0] KIND_EOL     = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNTERM   = 2'd1;
  localparam logic [1:0] ERR_MANY     = 2'd2;
  localparam logic [1:0] ERR_LONG     = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] MAX_ARGS_RESET = 8'd16;

  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [7:0] arg_index;
    logic [7:0] arg_length;
    logic [7:0] arg_count;
    logic       line_end_with_arg;
    logic [1:0] error_code;
    logic       drop_arg;
  } result_t;

endpackage

[design/qat_channels.sv]
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [7:0] arg_index;
  logic [7:0] arg_length;
  logic [7:0] arg_count;
  logic       line_end_with_arg;
  logic [1:0] error_code;
  logic       drop_arg;

  modport source (output valid, output kind, output out_char, output arg_index,
                  output arg_length, output arg_count, output line_end_with_arg,
                  output error_code, output drop_arg, input ready);
  modport sink (input valid, input kind, input out_char, input arg_index,
                input arg_length, input arg_count, input line_end_with_arg,
                input error_code, input drop_arg, output ready);
endinterface

interface qat_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_args;

  modport source (output valid, output max_args, input ready);
  modport sink (input valid, input max_args, output ready);
endinterface

[design/quoted_argument_tokenizer.sv]
// Splits a zero-terminated line, fed one byte per transfer, into arguments.
// Each byte yields at most one result: a decoded argument byte, an end of
// argument with its length, or an end of line with the argument count and
// any error (unterminated quote, too many arguments, argument too long).
// Sustained rate is one byte per cycle; the front end classifies the byte
// and writes it into a two-entry queue, and the back end takes one queued
// byte per cycle whenever its output register is empty or being drained.
// A byte passes the queue, then the output register. The max_args
// register resets to 16 and should be written only while the block is idle.
module quoted_argument_tokenizer #(
  parameter int MAX_ARG_LEN = 255
) (
  input logic       clk,
  input logic       rst_n,
  qat_in_if.sink    in_ch,
  qat_out_if.source out_ch,
  qat_cfg_if.sink   cfg_ch
);
  import qat_pkg::*;

  logic    q_ready;
  logic    push;
  token_t  push_tok;
  logic    pop;
  logic    pop_valid;
  token_t  pop_tok;
  logic    res_valid;
  result_t res;

  assign cfg_ch.ready = 1'b1;

  qat_front u_front (
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.in_byte),
    .in_ready (in_ch.ready),
    .q_ready  (q_ready),
    .push     (push),
    .push_tok (push_tok)
  );

  qat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_tok    (pop_tok),
    .pop_valid  (pop_valid)
  );

  qat_back #(
    .MAX_ARG_LEN (MAX_ARG_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.max_args),
    .tok_valid (pop_valid),
    .tok       (pop_tok),
    .tok_pop   (pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.valid             = res_valid;
  assign out_ch.kind              = res.kind;
  assign out_ch.out_char          = res.out_char;
  assign out_ch.arg_index         = res.arg_index;
  assign out_ch.arg_length        = res.arg_length;
  assign out_ch.arg_count         = res.arg_count;
  assign out_ch.line_end_with_arg = res.line_end_with_arg;
  assign out_ch.error_code        = res.error_code;
  assign out_ch.drop_arg          = res.drop_arg;

endmodule

[design/qat_front.sv]
module qat_front (
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  logic            q_ready,
  output logic            push,
  output qat_pkg::token_t push_tok
);
  import qat_pkg::*;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  always_comb begin
    push_tok.ch = in_byte;
    case (in_byte)
      CH_N:    push_tok.esc_ch = CH_LF;
      CH_T:    push_tok.esc_ch = CH_TAB;
      default: push_tok.esc_ch = in_byte;
    endcase
    if (in_byte == CH_NUL) begin
      push_tok.cls = CLS_END;
    end else if (in_byte inside {CH_SPACE, CH_LF, CH_TAB}) begin
      push_tok.cls = CLS_SEP;
    end else if (in_byte == CH_DQUOTE) begin
      push_tok.cls = CLS_QUOTE;
    end else if (in_byte == CH_BSLASH) begin
      push_tok.cls = CLS_BSLASH;
    end else begin
      push_tok.cls = CLS_OTHER;
    end
  end

endmodule

[design/qat_queue.sv]
module qat_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qat_pkg::token_t push_tok,
  output logic            push_ready,
  input  logic            pop,
  output qat_pkg::token_t pop_tok,
  output logic            pop_valid
);
  import qat_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  token_t          mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign push_ready = (count_r != FullCnt);
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[design/qat_back.sv]
module qat_back #(
  parameter int MAX_ARG_LEN = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  logic             tok_valid,
  input  qat_pkg::token_t  tok,
  output logic             tok_pop,
  output logic             res_valid,
  output qat_pkg::result_t res,
  input  logic             res_ready
);
  import qat_pkg::*;

  localparam logic [7:0] LenMax = 8'(MAX_ARG_LEN);

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_ESCAPE,
    MODE_ENDED,
    MODE_EXCESS
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic       trunc_r, trunc_nxt;
  logic [7:0] max_args_r;
  logic       out_valid_r;
  result_t    res_r;

  logic       fire;
  logic       emit;
  logic       do_add;
  logic [7:0] add_base;
  logic [7:0] add_ch;
  result_t    res_nxt;

  assign fire      = tok_valid && (!out_valid_r || res_ready);
  assign tok_pop   = fire;
  assign res_valid = out_valid_r;
  assign res       = res_r;

  assign add_base = (mode_r == MODE_SKIP) ? 8'd0 : len_r;
  assign add_ch   = (mode_r == MODE_ESCAPE) ? tok.esc_ch : tok.ch;

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    trunc_nxt = trunc_r;
    emit      = 1'b0;
    do_add    = 1'b0;
    res_nxt   = '0;

    if (tok.cls == CLS_END) begin
      emit             = 1'b1;
      res_nxt.kind     = KIND_EOL;
      res_nxt.arg_count = cnt_r;
      case (mode_r)
        MODE_PLAIN: begin
          res_nxt.arg_index         = cnt_r;
          res_nxt.arg_length        = len_r;
          res_nxt.arg_count         = cnt_r + 8'd1;
          res_nxt.line_end_with_arg = 1'b1;
          res_nxt.error_code        = trunc_r ? ERR_LONG : ERR_NONE;
        end
        MODE_QUOTED, MODE_ESCAPE: begin
          res_nxt.error_code = ERR_UNTERM;
          res_nxt.drop_arg   = 1'b1;
        end
        MODE_EXCESS: res_nxt.error_code = ERR_MANY;
        default: res_nxt.error_code = ERR_NONE;
      endcase
      // back to a clean line
      mode_nxt  = MODE_SKIP;
      cnt_nxt   = '0;
      len_nxt   = '0;
      trunc_nxt = 1'b0;
    end else begin
      case (mode_r)
        MODE_SKIP: begin
          if (tok.cls != CLS_SEP) begin
            len_nxt   = '0;
            trunc_nxt = 1'b0;
            if (tok.cls == CLS_QUOTE) begin
              mode_nxt = MODE_QUOTED;
            end else begin
              mode_nxt = MODE_PLAIN;
              do_add   = 1'b1;
            end
          end
        end
        MODE_PLAIN: begin
          if (tok.cls == CLS_SEP) begin
            emit               = 1'b1;
            res_nxt.kind       = KIND_ARG_END;
            res_nxt.arg_index  = cnt_r;
            res_nxt.arg_length = len_r;
            res_nxt.error_code = trunc_r ? ERR_LONG : ERR_NONE;
            cnt_nxt            = cnt_r + 8'd1;
            mode_nxt           = MODE_SKIP;
          end else begin
            do_add = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (tok.cls == CLS_QUOTE) begin
            if (len_r == '0) begin
              // empty quotes end the argument list
              mode_nxt = MODE_ENDED;
            end else begin
              emit               = 1'b1;
              res_nxt.kind       = KIND_ARG_END;
              res_nxt.arg_index  = cnt_r;
              res_nxt.arg_length = len_r;
              res_nxt.error_code = trunc_r ? ERR_LONG : ERR_NONE;
              cnt_nxt            = cnt_r + 8'd1;
              mode_nxt           = MODE_SKIP;
            end
          end else if (tok.cls == CLS_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            do_add = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          mode_nxt = MODE_QUOTED;
          do_add   = 1'b1;
        end
        default: ;
      endcase

      if (do_add) begin
        if (add_base == '0 && cnt_r >= max_args_r) begin
          mode_nxt = MODE_EXCESS;
        end else if (add_base >= LenMax) begin
          trunc_nxt = 1'b1;
        end else begin
          len_nxt           = add_base + 8'd1;
          emit              = 1'b1;
          res_nxt.kind      = KIND_CHAR;
          res_nxt.out_char  = add_ch;
          res_nxt.arg_index = cnt_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SKIP;
      cnt_r       <= '0;
      len_r       <= '0;
      trunc_r     <= 1'b0;
      max_args_r  <= MAX_ARGS_RESET;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      if (cfg_we) begin
        max_args_r <= cfg_data;
      end
      if (fire) begin
        mode_r  <= mode_nxt;
        cnt_r   <= cnt_nxt;
        len_r   <= len_nxt;
        trunc_r <= trunc_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
        res_r       <= res_nxt;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
